// ----- rtl/kerl_pkg.sv -----
package kerl_pkg;

    // Table geometry.
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Field widths.
    localparam int ADDR_W    = 48;
    localparam int SUBTYPE_W = 8;
    localparam int TICK_W    = 32;
    localparam int VERDICT_W = 2;

    // Window length after reset, in ticks.
    localparam logic [TICK_W-1:0] WINDOW_RESET = TICK_W'(100);

    // Verdict codes.
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ALLOW    = 2'd0,
        VERDICT_SUPPRESS = 2'd1,
        VERDICT_FULL     = 2'd2
    } t_verdict;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;      // capture a new request and restart the scan
        logic     step;      // note free or expired slot, advance the index
        logic     renew;     // write the current tick into the matching slot
        logic     claim;     // store the key in the chosen free or expired slot
        logic     out_load;  // load the output register
        t_verdict verdict;   // verdict for the output register
    } t_kerl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;           // slot under scan is used and holds the key
        logic in_window;     // elapsed time of the slot under scan is below the window
        logic last;          // slot under scan is the last one
        logic have_free;     // a free slot was seen during the scan
        logic have_expired;  // an expired slot was seen during the scan
    } t_kerl_status;

endpackage

// ----- rtl/kerl_dp.sv -----
module kerl_dp
    import kerl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [TICK_W-1:0]    i_cfg_wdata,
    input  logic [ADDR_W-1:0]    i_dest_address,
    input  logic [SUBTYPE_W-1:0] i_frame_subtype,
    input  logic [TICK_W-1:0]    i_current_tick,
    input  t_kerl_cmd            i_cmd,
    output t_kerl_status         o_status,
    output logic [VERDICT_W-1:0] o_verdict
);

    // Slot table. Key and tick entries are only meaningful while the valid bit is set.
    logic [ADDR_W-1:0]    r_key_addr [NUM_SLOTS];
    logic [SUBTYPE_W-1:0] r_key_sub  [NUM_SLOTS];
    logic [TICK_W-1:0]    r_last_tick[NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;

    // Configuration and captured request.
    logic [TICK_W-1:0]    r_window;
    logic [ADDR_W-1:0]    r_addr;
    logic [SUBTYPE_W-1:0] r_sub;
    logic [TICK_W-1:0]    r_tick;

    // Scan state.
    logic [SLOT_W-1:0]    r_idx;
    logic                 r_have_free;
    logic                 r_have_exp;
    logic [SLOT_W-1:0]    r_free_idx;
    logic [SLOT_W-1:0]    r_exp_idx;
    t_verdict             r_verdict;

    logic [TICK_W-1:0]    elapsed;
    logic                 slot_used;
    logic                 in_window;
    logic [SLOT_W-1:0]    claim_idx;

    // Compare the slot under scan against the captured key.
    always_comb begin
        slot_used = r_valid[r_idx];
        elapsed   = r_tick - r_last_tick[r_idx];
        in_window = (elapsed < r_window);
        claim_idx = r_have_free ? r_free_idx : r_exp_idx;
    end

    assign o_status.hit          = slot_used && (r_key_sub[r_idx] == r_sub)
                                   && (r_key_addr[r_idx] == r_addr);
    assign o_status.in_window    = in_window;
    assign o_status.last         = (r_idx == SLOT_W'(NUM_SLOTS - 1));
    assign o_status.have_free    = r_have_free;
    assign o_status.have_expired = r_have_exp;
    assign o_verdict             = r_verdict;

    // Control registers: window, valid bits and scan tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_valid     <= '0;
            r_idx       <= '0;
            r_have_free <= 1'b0;
            r_have_exp  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_have_free <= 1'b0;
                r_have_exp  <= 1'b0;
            end else if (i_cmd.step) begin
                if (!slot_used && !r_have_free) begin
                    r_have_free <= 1'b1;
                end
                if (slot_used && !in_window && !r_have_exp) begin
                    r_have_exp <= 1'b1;
                end
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (i_cmd.claim) begin
                r_valid[claim_idx] <= 1'b1;
            end
        end
    end

    // Payload registers: request capture, slot indexes, table entries and verdict.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_dest_address;
            r_sub  <= i_frame_subtype;
            r_tick <= i_current_tick;
        end
        if (i_cmd.step) begin
            if (!slot_used && !r_have_free) begin
                r_free_idx <= r_idx;
            end
            if (slot_used && !in_window && !r_have_exp) begin
                r_exp_idx <= r_idx;
            end
        end
        if (i_cmd.renew) begin
            r_last_tick[r_idx] <= r_tick;
        end
        if (i_cmd.claim) begin
            r_key_addr[claim_idx]  <= r_addr;
            r_key_sub[claim_idx]   <= r_sub;
            r_last_tick[claim_idx] <= r_tick;
        end
        if (i_cmd.out_load) begin
            r_verdict <= i_cmd.verdict;
        end
    end

endmodule

// ----- rtl/kerl_ctrl.sv -----
module kerl_ctrl
    import kerl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    input  t_kerl_status i_status,
    output t_kerl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_DONE
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_verdict r_code;
    t_verdict n_code;
    logic     r_out_valid;
    logic     n_out_valid;
    logic     out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.verdict = r_code;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    if (i_status.in_window) begin
                        n_code = VERDICT_SUPPRESS;
                    end else begin
                        o_cmd.renew = 1'b1;
                        n_code      = VERDICT_ALLOW;
                    end
                    n_state = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_RESOLVE;
                    end
                end
            end
            ST_RESOLVE: begin
                if (i_status.have_free || i_status.have_expired) begin
                    o_cmd.claim = 1'b1;
                    n_code      = VERDICT_ALLOW;
                end else begin
                    n_code = VERDICT_FULL;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_code      <= VERDICT_ALLOW;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    // A tick is renewed only for a matching slot whose window has run out.
    a_renew_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.renew |-> (i_status.hit && !i_status.in_window))
        else $error("renew without an expired matching slot");

    // A slot is claimed only when the scan found a free or expired one.
    a_claim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.claim |-> (i_status.have_free || i_status.have_expired))
        else $error("claim without a free or expired slot");

    // Loading the output register always presents a result next cycle.
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    // A new request is never captured while a scan is in progress.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_RESOLVE) |-> !o_cmd.load)
        else $error("request captured during a scan");
`endif

endmodule

// ----- rtl/keyed_event_rate_limiter.sv -----
// An accepted request is scanned against the table one slot per cycle; a key match
// ends the scan at the matching slot, a miss scans all 8 slots. A new request is
// accepted only once the previous verdict is loaded into the output register.
// The output register lets a new request be accepted while a verdict waits.
// Reset (synchronous, active low) frees all slots at once and sets the window to 100.
module keyed_event_rate_limiter
    import kerl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [TICK_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ADDR_W-1:0]    i_dest_address,
    input  logic [SUBTYPE_W-1:0] i_frame_subtype,
    input  logic [TICK_W-1:0]    i_current_tick,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [VERDICT_W-1:0] o_verdict
);

    t_kerl_cmd    cmd;
    t_kerl_status status;

    // Sequencer for the scan and the output handshake.
    kerl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Slot table, compare logic and verdict register.
    kerl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_dest_address  (i_dest_address),
        .i_frame_subtype (i_frame_subtype),
        .i_current_tick  (i_current_tick),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_verdict       (o_verdict)
    );

endmodule
